### sv/rpc_pkg.sv
package rpc_pkg;

    // Operand and result widths are fixed by the word formats below
    localparam int OPERAND_BITS = 16;
    // Fraction bits carried below the operand LSB in the coordinate path
    localparam int GUARD        = 20;
    // Coordinate width: operand, guard bits, CORDIC growth and sign headroom
    localparam int CW           = OPERAND_BITS + GUARD + 3;
    // Angle accumulator width: pi is 2^31, plus headroom for the pre-rotation
    localparam int ZW           = 34;
    // Product width of operand times gain
    localparam int PW           = OPERAND_BITS + 32;
    // Width after rounding a coordinate back to operand scale
    localparam int RW           = CW - GUARD;
    localparam int TABLE_LEN    = 24;

    // CORDIC gain compensation, 0.60725293500888 in Q31
    localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

    localparam logic signed [ZW-1:0] ANG_PI      = ZW'(64'h8000_0000);
    localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(64'h4000_0000);
    // Rounding offsets (add half, then floor shift)
    localparam logic signed [CW-1:0] X_HALF = CW'(64'd1 << (GUARD - 1));
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'd1 << (31 - OPERAND_BITS));

    // Saturation limits at rounded scale
    localparam logic signed [RW-1:0] SAT_LO =
        {{(RW - OPERAND_BITS + 1){1'b1}}, {(OPERAND_BITS - 1){1'b0}}};
    localparam logic signed [RW-1:0] SAT_X_HI =
        {{(RW - OPERAND_BITS){1'b0}}, {OPERAND_BITS{1'b1}}};
    localparam logic signed [RW-1:0] SAT_Y_HI =
        {{(RW - OPERAND_BITS + 1){1'b0}}, {(OPERAND_BITS - 1){1'b1}}};

    // atan(2^-i) in units where pi is 2^31
    localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic {
        REQ_RECT_TO_POLAR = 1'b0,
        REQ_POLAR_TO_RECT = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type                      req_type;
        logic signed [OPERAND_BITS-1:0] operand_a;
        logic signed [OPERAND_BITS-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [OPERAND_BITS:0]   result_x;
        logic signed [OPERAND_BITS-1:0] result_y;
    } t_res;

endpackage

### sv/rect_polar_converter.sv
// Rectangular / polar converter, pipelined CORDIC.
//
// Request word: start together with i_req (req_type, operand_a, operand_b);
// a word is taken at each rising edge where start is high and busy is low.
// req_type 0 turns (real, imag) into (magnitude, angle), req_type 1 turns
// (magnitude, angle) into (real, imag). Angles are binary: -2^15 is -pi.
// Result word: o_res is valid for exactly one cycle, flagged by o_strobe.
//
// Pipeline: an accepted word passes through one gain multiply stage, one
// quadrant stage, one stage per CORDIC micro-rotation and one
// round/saturate stage before the strobe. Throughput is one word per
// cycle; every stage is a register slice of the unrolled CORDIC.
//
// Reset (synchronous, active low) clears the stage valid bits, so words in
// flight are dropped; busy is high while reset is held and until the run
// flag is set after it, low otherwise. The receiver cannot hold results off and
// the pipeline never stalls.
module rect_polar_converter
    import rpc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    // Run flag: block takes words once out of reset
    logic r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy = ~(r_run & i_rst_n);

    logic accept;
    assign accept = start & ~busy;

    // ---------------------------------------------------------------
    // Stage A: gain compensation multiply of both operands
    // ---------------------------------------------------------------
    logic signed [PW-1:0] prod_a, prod_b;
    logic signed [PW-1:0] gain_ext;

    assign gain_ext = $signed({{(PW - 31){1'b0}}, GAIN_Q31});

    always_comb begin
        prod_a = $signed({{(PW - OPERAND_BITS){i_req.operand_a[OPERAND_BITS-1]}},
                          i_req.operand_a}) * gain_ext;
        prod_b = $signed({{(PW - OPERAND_BITS){i_req.operand_b[OPERAND_BITS-1]}},
                          i_req.operand_b}) * gain_ext;
    end

    logic signed [PW-1:0] sh_a, sh_b;
    assign sh_a = prod_a >>> (31 - GUARD);
    assign sh_b = prod_b >>> (31 - GUARD);

    logic                           r_vld_a;
    t_req_type                      r_mode_a;
    logic                           r_zero_a;
    logic signed [CW-1:0]           r_pa, r_pb;
    logic signed [OPERAND_BITS-1:0] r_a, r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= accept;
        end
        r_mode_a <= i_req.req_type;
        r_zero_a <= (i_req.req_type == REQ_RECT_TO_POLAR) &&
                    (i_req.operand_a == '0) && (i_req.operand_b == '0);
        r_pa     <= sh_a[CW-1:0];
        r_pb     <= sh_b[CW-1:0];
        r_a      <= i_req.operand_a;
        r_b      <= i_req.operand_b;
    end

    // ---------------------------------------------------------------
    // Stage B: quadrant pre-rotation into the CORDIC convergence range
    // ---------------------------------------------------------------
    logic signed [CW-1:0] r_x    [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_y    [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z    [0:CORDIC_STAGES];
    t_req_type            r_mode [0:CORDIC_STAGES];
    logic                 r_zero [0:CORDIC_STAGES];
    logic                 r_vld  [0:CORDIC_STAGES];

    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    logic signed [ZW-1:0] ang_b;

    // Angle operand scaled so that pi is 2^31
    assign ang_b = {{(ZW - 32){r_b[OPERAND_BITS-1]}}, r_b, {(32 - OPERAND_BITS){1'b0}}};

    always_comb begin
        n_x0 = r_pa;
        n_y0 = r_pb;
        n_z0 = '0;
        unique case (r_mode_a)
            REQ_POLAR_TO_RECT: begin
                n_y0 = '0;
                n_z0 = ang_b;
                if (ang_b > ANG_HALF_PI) begin
                    n_z0 = ang_b - ANG_PI;
                    n_x0 = -r_pa;
                end else if (ang_b < -ANG_HALF_PI) begin
                    n_z0 = ang_b + ANG_PI;
                    n_x0 = -r_pa;
                end
            end
            REQ_RECT_TO_POLAR: begin
                // Left half plane: flip through the origin and start at +/-pi
                if (r_a[OPERAND_BITS-1]) begin
                    n_z0 = r_b[OPERAND_BITS-1] ? -ANG_PI : ANG_PI;
                    n_x0 = -r_pa;
                    n_y0 = -r_pb;
                end
            end
            default: begin
                n_x0 = r_pa;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_vld_a;
        end
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
        r_mode[0] <= r_mode_a;
        r_zero[0] <= r_zero_a;
    end

    // ---------------------------------------------------------------
    // CORDIC micro-rotations, one register stage each
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] ang_step;
        logic                 sub;

        always_comb begin
            dx       = r_y[i] >>> i;
            dy       = r_x[i] >>> i;
            ang_step = $signed({{(ZW - 32){1'b0}}, ATAN_TAB[i]});
            // Rotation drives z to zero, vectoring drives y to zero
            sub      = (r_mode[i] == REQ_POLAR_TO_RECT) ? ~r_z[i][ZW-1] : r_y[i][CW-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            if (sub) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - ang_step;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + ang_step;
            end
            r_mode[i+1] <= r_mode[i];
            r_zero[i+1] <= r_zero[i];
        end
    end

    // ---------------------------------------------------------------
    // Output stage: round half up, saturate, select per mode
    // ---------------------------------------------------------------
    logic signed [CW-1:0] sum_x, sum_y, sh_x, sh_y;
    logic signed [ZW-1:0] sum_z;
    logic signed [RW-1:0] rnd_x, rnd_y;
    t_res                 n_res;

    always_comb begin
        sum_x = r_x[CORDIC_STAGES] + X_HALF;
        sum_y = r_y[CORDIC_STAGES] + X_HALF;
        sum_z = r_z[CORDIC_STAGES] + Z_HALF;
        sh_x  = sum_x >>> GUARD;
        sh_y  = sum_y >>> GUARD;
        rnd_x = sh_x[RW-1:0];
        rnd_y = sh_y[RW-1:0];

        // Magnitude or real part
        if (rnd_x < SAT_LO) begin
            n_res.result_x = SAT_LO[OPERAND_BITS:0];
        end else if (rnd_x > SAT_X_HI) begin
            n_res.result_x = SAT_X_HI[OPERAND_BITS:0];
        end else begin
            n_res.result_x = rnd_x[OPERAND_BITS:0];
        end

        // Imaginary part, or angle (wraps so that +pi reads as -pi)
        if (r_mode[CORDIC_STAGES] == REQ_POLAR_TO_RECT) begin
            if (rnd_y < SAT_LO) begin
                n_res.result_y = SAT_LO[OPERAND_BITS-1:0];
            end else if (rnd_y > SAT_Y_HI) begin
                n_res.result_y = SAT_Y_HI[OPERAND_BITS-1:0];
            end else begin
                n_res.result_y = rnd_y[OPERAND_BITS-1:0];
            end
        end else begin
            n_res.result_y = sum_z[31:32-OPERAND_BITS];
        end

        // Zero vector has no angle: report zero
        if (r_zero[CORDIC_STAGES]) begin
            n_res = '0;
        end
    end

    logic r_strobe;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[CORDIC_STAGES];
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef NO_ASSERTIONS
    // Every accepted word comes out after the fixed pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(CORDIC_STAGES + 3) o_strobe)
        else $error("accepted word did not reach the output on time");

    // A zero vector gives magnitude 0 and angle 0
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_RECT_TO_POLAR &&
         i_req.operand_a == '0 && i_req.operand_b == '0)
        |-> ##(CORDIC_STAGES + 3) (o_res == '0))
        else $error("zero vector did not give a zero result");

    // Zero magnitude stays at the origin at any angle
    a_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_POLAR_TO_RECT && i_req.operand_a == '0)
        |-> ##(CORDIC_STAGES + 3) (o_res == '0))
        else $error("zero magnitude did not give the origin");
`endif

endmodule

### sim/rect_polar_converter_test.sv
module rect_polar_converter_test;
    import rpc_pkg::*;

    localparam int N_STAGES    = 16;
    localparam int N_RANDOM    = 900;
    // pipeline depth plus margin for the drain at the end
    localparam int DRAIN_WAIT  = N_STAGES + 3 + 20;
    localparam int CYCLE_LIMIT = 400000;

    // fixed-point formats of the conversion
    localparam int  FRAC_BITS  = 20;
    localparam int  ANG_SHIFT  = 32 - OPERAND_BITS;
    localparam longint GAIN_K  = 64'sd1304065748;
    localparam longint PI_ANG  = 64'sd2147483648;
    localparam longint HALF_PI = 64'sd1073741824;
    localparam longint MAG_LO  = -64'sd32768;
    localparam longint MAG_HI  = 64'sd65535;
    localparam longint IM_HI   = 64'sd32767;

    // atan(2^-i), pi = 2^31
    localparam longint ATAN_STEP [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_res o_res;

    t_res exp_q[$];
    t_row dir_tab[$];
    int   errors;
    int   n_to_polar;
    int   n_to_rect;
    int   n_checked;
    int   cycles;

    rect_polar_converter #(
        .CORDIC_STAGES(N_STAGES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_strobe(o_strobe),
        .o_res(o_res)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint round_down(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // bit-exact CORDIC conversion in either direction
    function automatic t_res cordic_convert(t_req w);
        longint a, b, x, y, z, dx, dy, rx, ry;
        t_res   r;
        a = w.operand_a;
        b = w.operand_b;
        if (w.req_type == REQ_POLAR_TO_RECT) begin
            x = (a * GAIN_K) >>> (31 - FRAC_BITS);
            y = 0;
            z = b * (64'sd1 <<< ANG_SHIFT);
            // fold the angle into the right half plane
            if (z > HALF_PI) begin
                z = z - PI_ANG;
                x = -x;
            end else if (z < -HALF_PI) begin
                z = z + PI_ANG;
                x = -x;
            end
            for (int i = 0; i < N_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
                end
            end
            rx = clamp(round_down(x, FRAC_BITS), MAG_LO, MAG_HI);
            ry = clamp(round_down(y, FRAC_BITS), MAG_LO, IM_HI);
        end else if (a == 0 && b == 0) begin
            rx = 0;
            ry = 0;
        end else begin
            x = (a * GAIN_K) >>> (31 - FRAC_BITS);
            y = (b * GAIN_K) >>> (31 - FRAC_BITS);
            z = 0;
            // left half plane: start from +/-pi and mirror the vector
            if (a < 0) begin
                z = (b >= 0) ? PI_ANG : -PI_ANG;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < N_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y < 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
                end
            end
            rx = clamp(round_down(x, FRAC_BITS), MAG_LO, MAG_HI);
            // +pi wraps to -pi by truncation
            ry = round_down(z, ANG_SHIFT);
        end
        r.result_x = rx[OPERAND_BITS:0];
        r.result_y = ry[OPERAND_BITS-1:0];
        return r;
    endfunction

    function automatic void add_row(t_req_type k, int a, int b, bit fixed = 1'b0,
                                    int ex = 0, int ey = 0);
        t_row row;
        row.req.req_type  = k;
        row.req.operand_a = a[OPERAND_BITS-1:0];
        row.req.operand_b = b[OPERAND_BITS-1:0];
        row.fixed         = fixed;
        row.res.result_x  = ex[OPERAND_BITS:0];
        row.res.result_y  = ey[OPERAND_BITS-1:0];
        dir_tab.push_back(row);
    endfunction

    // operand mix: full range, extremes, near zero, quadrant edges (angles) or +/-1024 (others), near full scale
    function automatic logic [OPERAND_BITS-1:0] pick_operand(bit is_angle);
        int v;
        int corners [0:5] = '{-32768, -32767, -1, 0, 1, 32767};
        int quads   [0:3] = '{-32768, -16384, 0, 16384};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5:             v = corners[$urandom_range(0, 5)];
            6, 7:          v = int'($urandom_range(0, 32)) - 16;
            8: begin
                if (is_angle)
                    v = quads[$urandom_range(0, 3)] + int'($urandom_range(0, 8)) - 4;
                else
                    v = int'($urandom_range(0, 2047)) - 1024;
            end
            default: begin
                v = 32767 - int'($urandom_range(0, 15));
                if ($urandom_range(0, 1)) v = -v - 1;
            end
        endcase
        return v[OPERAND_BITS-1:0];
    endfunction

    // present one word and hold it until taken
    task automatic send_word(input t_req w, input t_res want);
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        exp_q.push_back(want);
        if (w.req_type == REQ_RECT_TO_POLAR) n_to_polar++;
        else n_to_rect++;
    endtask

    // idle cycles with junk on the request bus
    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            i_req <= t_req'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int gap_len(bit dense);
        int p;
        if (dense) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result word x=%0d y=%0d", $time,
                         o_res.result_x, o_res.result_y);
                errors++;
            end else begin
                want = exp_q.pop_front();
                n_checked++;
                if (o_res.result_x !== want.result_x) begin
                    $display("%0t: result_x expected %0d actual %0d", $time,
                             want.result_x, o_res.result_x);
                    errors++;
                end
                if (o_res.result_y !== want.result_y) begin
                    $display("%0t: result_y expected %0d actual %0d", $time,
                             want.result_y, o_res.result_y);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still pending", $time, exp_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_req w;
        t_res want;
        bit   dense;
        errors     = 0;
        n_to_polar = 0;
        n_to_rect  = 0;
        n_checked  = 0;
        cycles     = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;

        // directed words; zero vectors have an obvious answer
        add_row(REQ_RECT_TO_POLAR, 0, 0, 1'b1, 0, 0);
        add_row(REQ_RECT_TO_POLAR, 32767, 0);
        add_row(REQ_RECT_TO_POLAR, -32768, 0);          // angle lands on +pi, wraps
        add_row(REQ_RECT_TO_POLAR, 0, 32767);
        add_row(REQ_RECT_TO_POLAR, 0, -32768);
        add_row(REQ_RECT_TO_POLAR, 32767, 32767);       // largest magnitude in the first quadrant
        add_row(REQ_RECT_TO_POLAR, -32768, -32768);
        add_row(REQ_RECT_TO_POLAR, -32768, 32767);
        add_row(REQ_RECT_TO_POLAR, 1, 0);
        add_row(REQ_RECT_TO_POLAR, -1, 0);
        add_row(REQ_RECT_TO_POLAR, 0, 1);
        add_row(REQ_RECT_TO_POLAR, -1, -1);
        add_row(REQ_RECT_TO_POLAR, 1, -1);
        add_row(REQ_POLAR_TO_RECT, 0, 0, 1'b1, 0, 0);
        add_row(REQ_POLAR_TO_RECT, 0, -32768, 1'b1, 0, 0);
        add_row(REQ_POLAR_TO_RECT, 32767, 0);
        add_row(REQ_POLAR_TO_RECT, 32767, -32768);      // -pi
        add_row(REQ_POLAR_TO_RECT, 32767, 32767);
        add_row(REQ_POLAR_TO_RECT, 32767, 16384);
        add_row(REQ_POLAR_TO_RECT, 32767, -16384);
        add_row(REQ_POLAR_TO_RECT, -32768, -16384);     // imag part saturates
        add_row(REQ_POLAR_TO_RECT, -32768, 0);          // negative magnitude
        add_row(REQ_POLAR_TO_RECT, -32768, -32768);
        add_row(REQ_POLAR_TO_RECT, 32767, 8192);
        add_row(REQ_POLAR_TO_RECT, 1, 12345);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            want = dir_tab[k].fixed ? dir_tab[k].res : cordic_convert(dir_tab[k].req);
            send_word(dir_tab[k].req, want);
            hold_off(gap_len(k < 12));
        end

        // random words, in blocks of 64 that are back-to-back or gappy at random
        dense = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 64 == 0) dense = ($urandom_range(0, 3) == 0);
            w.req_type  = t_req_type'($urandom_range(0, 1));
            w.operand_a = pick_operand(1'b0);
            w.operand_b = pick_operand(w.req_type == REQ_POLAR_TO_RECT);
            send_word(w, cordic_convert(w));
            hold_off(gap_len(dense));
        end
        start <= 1'b0;

        while (exp_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("converted %0d rectangular->polar and %0d polar->rectangular words",
                 n_to_polar, n_to_rect);
        $display("%0d result words compared, %0d mismatches", n_checked, errors);
        if (errors == 0 && exp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
sv/rpc_pkg.sv
sv/rect_polar_converter.sv
sim/rect_polar_converter_test.sv
